// ----- sv/wsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_pkg: shared types and constants of the frame unmasker
// Token format carried from the header parser to the unmask stage.
// ----------------------------------------------------------------------------
package wsu_pkg;

  // Length codes that call for an extended length field
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Header byte positions
  localparam logic [3:0] HDR_POS_FLAGS = 4'd0;
  localparam logic [3:0] HDR_POS_LEN   = 4'd1;
  localparam logic [3:0] HDR_POS_EXT   = 4'd2;
  // Last header position is HDR_POS_LAST_BASE + extended length bytes
  localparam logic [3:0] HDR_POS_LAST_BASE = 4'd5;

  // One pending result: raw byte, its mask byte and flags
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
    logic       err;
  } token_t;

endpackage : wsu_pkg
`default_nettype wire

// ----- sv/websocket_frame_unmasker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_unmasker: client-to-server frame deframer and unmasker
// Strips frame headers and unmasks payload bytes, one stream byte per cycle while full is low.
// ----------------------------------------------------------------------------
// Feed the received stream one byte per transfer on push/in_rx_byte; read
// unmasked payload bytes through empty/pop. The block takes one byte every
// cycle as long as full is low, and delivers one result per cycle as long as
// the reader keeps popping. Each header (flags byte, length byte, optional
// 16- or 64-bit big-endian extended length, 4 mask bytes) is consumed
// without producing results; every payload byte comes out XORed with the
// rotating mask, and the last byte of each frame carries out_frame_last.
// Empty frames produce nothing. A length byte without the mask bit produces
// a single result with out_frame_error set, and from then on all input is
// swallowed until reset. full rises only when QDEPTH results are queued
// behind an unread result register, so the total buffering is QDEPTH + 1
// results.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // stream in
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  // results out
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_last,
  output logic       out_frame_error
);
  import wsu_pkg::*;

  logic   take;       // input transfer this cycle
  token_t f_tok;      // token built by the parser
  logic   f_tok_valid;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  token_t q_tok;

  // Input transfer: parser state advances on every accepted byte, results
  // go into the queue in the same edge.
  assign take = push && !q_full;
  assign full = q_full;

  // Front: header parsing and payload tagging
  wsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .tok       (f_tok),
    .tok_valid (f_tok_valid)
  );

  // Decoupling queue between parser and output side
  wsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take && f_tok_valid),
    .wdata (f_tok),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_tok),
    .empty (q_empty)
  );

  // Back: unmask and hold the result for the reader
  wsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_tok        (q_tok),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .payload_byte (out_payload_byte),
    .frame_last   (out_frame_last),
    .frame_error  (out_frame_error)
  );

endmodule : websocket_frame_unmasker
`default_nettype wire

// ----- sv/wsu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_front: frame header parser
// Walks each frame header, tracks remaining payload and tags payload bytes
// with their mask byte. Emits one token per result.
// ----------------------------------------------------------------------------
module wsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output wsu_pkg::token_t tok,
  output logic            tok_valid
);
  import wsu_pkg::*;

  typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_LOCKED} state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [6:0]  len_code_r, len_code_nxt;
  logic [63:0] len_r, len_nxt;       // remaining payload bytes
  logic [31:0] mask_r, mask_nxt;     // rotates left one byte per payload byte
  logic [3:0]  ext_bytes;

  always_comb begin
    if (len_code_r == LEN_CODE_16) begin
      ext_bytes = 4'd2;
    end else if (len_code_r == LEN_CODE_64) begin
      ext_bytes = 4'd8;
    end else begin
      ext_bytes = 4'd0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_code_nxt = len_code_r;
    len_nxt      = len_r;
    mask_nxt     = mask_r;
    tok          = '0;
    tok.data     = rx_byte;
    tok.mask     = mask_r[31:24];
    tok_valid    = 1'b0;
    if (take) begin
      unique case (state_r)
        ST_HEADER: begin
          if (hdr_cnt_r == HDR_POS_FLAGS) begin
            hdr_cnt_nxt = HDR_POS_LEN;
          end else if (hdr_cnt_r == HDR_POS_LEN) begin
            if (!rx_byte[7]) begin
              // unmasked frame: report once and lock
              state_nxt = ST_LOCKED;
              tok_valid = 1'b1;
              tok.data  = '0;
              tok.mask  = '0;
              tok.err   = 1'b1;
            end else begin
              len_code_nxt = rx_byte[6:0];
              if (rx_byte[6:0] == LEN_CODE_16 || rx_byte[6:0] == LEN_CODE_64) begin
                len_nxt = '0;
              end else begin
                len_nxt = {57'd0, rx_byte[6:0]};
              end
              mask_nxt    = '0;
              hdr_cnt_nxt = HDR_POS_EXT;
            end
          end else begin
            if (hdr_cnt_r < HDR_POS_EXT + ext_bytes) begin
              len_nxt = {len_r[55:0], rx_byte};
            end else begin
              mask_nxt = {mask_r[23:0], rx_byte};
            end
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
            if (hdr_cnt_r == HDR_POS_LAST_BASE + ext_bytes) begin
              // last mask byte; empty frames go straight to the next header
              if (len_r == '0) begin
                hdr_cnt_nxt = HDR_POS_FLAGS;
              end else begin
                state_nxt = ST_PAYLOAD;
              end
            end
          end
        end
        ST_PAYLOAD: begin
          tok_valid = 1'b1;
          mask_nxt  = {mask_r[23:0], mask_r[31:24]};
          len_nxt   = len_r - 64'd1;
          if (len_r == 64'd1) begin
            tok.last    = 1'b1;
            state_nxt   = ST_HEADER;
            hdr_cnt_nxt = HDR_POS_FLAGS;
          end
        end
        default: begin
          // locked until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HEADER;
      hdr_cnt_r  <= '0;
      len_code_r <= '0;
      len_r      <= '0;
      mask_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      len_code_r <= len_code_nxt;
      len_r      <= len_nxt;
      mask_r     <= mask_nxt;
    end
  end

endmodule : wsu_front
`default_nettype wire

// ----- sv/wsu_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_queue: token queue between parser and unmask stage
// Small circular buffer; head entry is shown combinationally.
// ----------------------------------------------------------------------------
module wsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsu_pkg::token_t wdata,
  output logic            full,
  input  logic            pop,
  output wsu_pkg::token_t rdata,
  output logic            empty
);
  import wsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count above depth");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a lone push");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

endmodule : wsu_queue
`default_nettype wire

// ----- sv/wsu_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_back: unmask stage and result register
// Pulls tokens from the queue, XORs in the mask byte and holds the result.
// ----------------------------------------------------------------------------
module wsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  wsu_pkg::token_t q_tok,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      payload_byte,
  output logic            frame_last,
  output logic            frame_error
);
  import wsu_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       err_r;

  // refill when the result register is free or drains this cycle
  assign q_pop = !q_empty && (!valid_r || pop);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (pop && valid_r) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_tok.data ^ q_tok.mask;
      last_r <= q_tok.last;
      err_r  <= q_tok.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign empty        = !valid_r;
  assign payload_byte = data_r;
  assign frame_last   = last_r;
  assign frame_error  = err_r;

endmodule : wsu_back
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for websocket_frame_unmasker
// Streams masked frames into the deframer and checks every unmasked byte,
// frame-end and error flag against a cycle-free model of the deframer.
// ----------------------------------------------------------------------------
module tb;
  import wsu_pkg::*;

  // length byte: bit 7 says the payload is masked
  localparam logic [7:0] MASK_BIT = 8'h80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned IDLE_PCT = 19;
  // tail of the run after the drain (buffering is a handful of results)
  localparam int unsigned TAIL_CYCLES = 24;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_LOCKED
  } deframe_state_t;

  // one result as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } unmasked_t;

  // one stream byte waiting to be sent; hold_for_drain makes the sender
  // wait until every outstanding result has been read before sending it
  typedef struct {
    logic [7:0] data;
    bit         hold_for_drain;
  } stream_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_payload_byte;
  logic       out_frame_last;
  logic       out_frame_error;

  websocket_frame_unmasker u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_payload_byte (out_payload_byte),
    .out_frame_last   (out_frame_last),
    .out_frame_error  (out_frame_error)
  );

  // bytes still to send, and unmasked results still owed by the block
  stream_byte_t stream_q[$];
  unmasked_t    unmasked_q[$];

  // deframer model state
  deframe_state_t frame_st = ST_HEADER;
  logic [3:0]     hdr_pos = HDR_POS_FLAGS;
  logic [6:0]     len_code_q = '0;
  logic [63:0]    frame_len = '0;
  logic [31:0]    mask_q = '0;
  logic [63:0]    pay_cnt = '0;

  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frame_ends = 0;
  int unsigned frames_queued = 0;
  string       tail_kind;
  unmasked_t   want;

  // no idling on either side through this window
  wire quiet = (cycle_cnt >= 300) && (cycle_cnt < 900);

  initial begin
    forever #1 clk = ~clk;
  end

  // number of extended length bytes that follow a given length code
  function automatic int ext_count(input logic [6:0] code);
    if (code == LEN_CODE_16) return 2;
    if (code == LEN_CODE_64) return 8;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
  endtask

  // Advance the deframer model by one accepted byte and queue any result.
  task automatic unmask_predict(input logic [7:0] b);
    int        n_ext;
    int        sel;
    unmasked_t r;
    n_ext = ext_count(len_code_q);
    r = '0;
    case (frame_st)
      ST_HEADER: begin
        if (hdr_pos == HDR_POS_FLAGS) begin
          hdr_pos = HDR_POS_LEN;  // flags byte carries nothing we use
        end else if (hdr_pos == HDR_POS_LEN) begin
          if ((b & MASK_BIT) == 0) begin
            // unmasked client frame: one error result, then deaf until reset
            r.err = 1'b1;
            unmasked_q.push_back(r);
            frame_st = ST_LOCKED;
          end else begin
            len_code_q = b[6:0];
            frame_len = (ext_count(b[6:0]) == 0) ? 64'(b[6:0]) : 64'd0;
            mask_q = '0;
            hdr_pos = HDR_POS_EXT;
          end
        end else begin
          // extended length bytes first (big-endian), then the 4 mask bytes
          if (hdr_pos < HDR_POS_EXT + n_ext) frame_len = {frame_len[55:0], b};
          else mask_q = {mask_q[23:0], b};
          if (hdr_pos == HDR_POS_LAST_BASE + n_ext) begin
            pay_cnt = '0;
            hdr_pos = HDR_POS_FLAGS;
            // empty frame goes straight back to the next header
            if (frame_len != 0) frame_st = ST_PAYLOAD;
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
      end
      ST_PAYLOAD: begin
        // mask byte 0 is the first mask byte received (mask_q[31:24])
        sel = int'(pay_cnt[1:0]);
        r.data = b ^ mask_q[8 * (3 - sel) +: 8];
        pay_cnt = pay_cnt + 64'd1;
        r.last = (pay_cnt == frame_len);
        if (r.last) begin
          frame_st = ST_HEADER;
          hdr_pos = HDR_POS_FLAGS;
        end
        unmasked_q.push_back(r);
      end
      default: ;  // locked: everything is swallowed
    endcase
  endtask

  function automatic void queue_byte(input logic [7:0] b, input bit hold);
    stream_byte_t s;
    s.data = b;
    s.hold_for_drain = hold;
    stream_q.push_back(s);
  endfunction

  // One masked frame: flags, length byte, extended length, mask, payload.
  // n_pay is normally the frame length; fewer leaves the frame open.
  function automatic void queue_frame(input logic [7:0] flags, input logic [6:0] code,
                                      input logic [63:0] ext_len, input logic [31:0] mask,
                                      input int unsigned n_pay, input bit hold);
    int n_ext;
    n_ext = ext_count(code);
    queue_byte(flags, hold);
    queue_byte(MASK_BIT | 8'(code), 1'b0);
    for (int i = n_ext - 1; i >= 0; i--) queue_byte(ext_len[8 * i +: 8], 1'b0);
    for (int i = 3; i >= 0; i--) queue_byte(mask[8 * i +: 8], 1'b0);
    for (int unsigned i = 0; i < n_pay; i++) queue_byte(8'($urandom), 1'b0);
    frames_queued++;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: holds push and the byte from the falling edge; a byte is taken
  // at the next rising edge with push high and full low.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || stream_q.size() == 0) begin
      push <= 1'b0;
    end else if (stream_q[0].hold_for_drain && unmasked_q.size() != 0) begin
      push <= 1'b0;  // wait for the block to run dry
    end else if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      in_rx_byte <= stream_q[0].data;
    end
  end

  // Reader: random back-pressure on the result side
  always @(negedge clk) begin
    pop <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge check a result transfer first, then fold an
  // input transfer into the model, so a same-edge pair is always ordered.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, unmasked_q.size());
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (unmasked_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_payload_byte, 0);
      end else begin
        want = unmasked_q.pop_front();
        if (out_payload_byte !== want.data)
          report_mismatch("payload_byte", out_payload_byte, want.data);
        if (out_frame_last !== want.last)
          report_mismatch("frame_last", out_frame_last, want.last);
        if (out_frame_error !== want.err)
          report_mismatch("frame_error", out_frame_error, want.err);
        if (want.last) frame_ends++;
      end
    end
    if (rst_n && push && !full) begin
      unmask_predict(in_rx_byte);
      void'(stream_q.pop_front());
      bytes_sent++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    logic [6:0]  code;
    int unsigned len;

    // directed: empty frame with all-ones mask and flags
    queue_frame(8'hFF, 7'd0, '0, 32'hFFFF_FFFF, 0, 1'b0);
    // one-byte frame, all-zero flags and mask, payload of zero
    queue_byte(8'h00, 1'b0);
    queue_byte(MASK_BIT | 8'd1, 1'b0);
    repeat (4) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    frames_queued++;
    // 16-bit extended length of zero: non-minimal empty frame
    queue_frame(8'($urandom), LEN_CODE_16, 64'd0, 32'($urandom), 0, 1'b0);
    // 64-bit extended length of five, all-ones payload; mask wraps around
    queue_byte(8'($urandom), 1'b0);
    queue_byte(8'hFF, 1'b0);
    repeat (7) queue_byte(8'h00, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'h81, 1'b0);
    repeat (5) queue_byte(8'hFF, 1'b0);
    frames_queued++;

    // random frames, mostly short; the first waits for the block to drain
    while (stream_q.size() < RANDOM_BYTES) begin
      k = $urandom_range(99);
      if (k < 60) begin
        code = 7'($urandom_range(12));
        len = code;
      end else if (k < 70) begin
        code = 7'($urandom_range(125, 13));
        len = code;
      end else if (k < 85) begin
        code = LEN_CODE_16;
        len = (k == 84) ? $urandom_range(300) : $urandom_range(40);
      end else begin
        code = LEN_CODE_64;
        len = $urandom_range(40);
      end
      queue_frame(8'($urandom), code, 64'(len), 32'($urandom), len,
                  frames_queued == 4 || $urandom_range(39) == 0);
    end

    // The lock can only be left by reset, and a frame whose 64-bit length
    // has its top bit set never ends, so the run ends in one or the other.
    if ($urandom_range(1) == 0) begin
      tail_kind = "unmasked header and lock";
      queue_byte(8'($urandom), 1'b1);
      queue_byte(8'($urandom_range(127)), 1'b0);
      repeat (16) queue_byte(8'($urandom), 1'b0);
    end else begin
      tail_kind = "open frame with top length bit set";
      queue_frame(8'($urandom), LEN_CODE_64, {1'b1, 31'($urandom), 32'($urandom)},
                  32'($urandom), 48, 1'b1);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0) @(posedge clk);
    while (unmasked_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d results, %0d frame ends",
             bytes_sent, frames_queued, results_seen, frame_ends);
    $display("Run ended with %s", tail_kind);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- websocket_frame_unmasker.f -----
sv/wsu_pkg.sv
sv/wsu_front.sv
sv/wsu_queue.sv
sv/wsu_back.sv
sv/websocket_frame_unmasker.sv
verif/tb.sv
